// ----- design/hts_pkg.sv -----
// Shared types, constants and helpers of the homography transfer score block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package hts_pkg;

   localparam int PT_W       = 16;
   localparam int COEF_W     = 21;
   localparam int ROW_W      = 3 * COEF_W;
   localparam int THR_W      = 16;
   localparam int MAX_POINTS = 4096;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int SUM_W      = 30;
   localparam int MEAN_W     = 17;
   localparam int DOT_W      = 39;
   localparam int PROD_W     = COEF_W + PT_W;
   localparam int QUO_W      = 18;
   localparam int Q_W        = QUO_W + 1;
   localparam int NUM_SHIFT  = 13;
   localparam int PRE_SHIFT  = QUO_W - NUM_SHIFT;
   localparam int DIFF_W     = Q_W + 1;
   localparam int MAG_W      = 16;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int E_W        = SQ_W + 1;
   localparam int TERM_W     = THR_W + 1;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int DSTEP_W    = $clog2(QUO_W);
   localparam int MSTEP_W    = $clog2(SUM_W);

   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROW2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_THR  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA    = 3'd7;

   localparam logic [THR_W-1:0] THR_RESET   = 16'd1533;
   localparam logic [THR_W-1:0] GAMMA_RESET = 16'd1533;

   typedef struct packed {
      logic signed [PT_W-1:0] first_x;
      logic signed [PT_W-1:0] first_y;
      logic signed [PT_W-1:0] second_x;
      logic signed [PT_W-1:0] second_y;
      logic                   inlier;
      logic                   last_point;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_score;
      logic [CNT_W-1:0]  inlier_count;
      logic              no_inliers;
   } rsp_type;

   typedef struct packed {
      logic signed [PT_W-1:0] first_x;
      logic signed [PT_W-1:0] first_y;
      logic signed [PT_W-1:0] second_x;
      logic signed [PT_W-1:0] second_y;
      logic                   do_score;
      logic                   last;
   } job_type;

   typedef struct packed {
      logic [2:0][ROW_W-1:0] fwd_rows;
      logic [2:0][ROW_W-1:0] inv_rows;
      logic [THR_W-1:0]      error_threshold;
      logic [THR_W-1:0]      gamma_offset;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT,
      ST_DXS,
      ST_DXW,
      ST_DYS,
      ST_DYW,
      ST_SQX,
      ST_SQY,
      ST_TERM,
      ST_MSET,
      ST_MITER,
      ST_OUT
   } back_state_type;

   function automatic logic signed [COEF_W-1:0] coef(input logic [ROW_W-1:0] row,
                                                     input int j);
      return $signed(row[j*COEF_W +: COEF_W]);
   endfunction

endpackage

// ----- design/hts_queue.sv -----
// Two-entry job queue between the front and back parts of the score block.
// Depends on hts_pkg.
`timescale 1ns / 1ps
module hts_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hts_pkg::job_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output hts_pkg::job_type head
);
   import hts_pkg::*;

   job_type             mem_ff [QDEPTH];
   job_type             mem_in [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_data;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Job pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Job popped from an empty queue.");

endmodule

// ----- design/hts_front.sv -----
// Front part: takes correspondence transfers, decides which are scored and
// queues them for the back part. Depends on hts_pkg.
`timescale 1ns / 1ps
module hts_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hts_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output hts_pkg::job_type q_data
);
   import hts_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_score;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign do_score  = req_data.inlier && (cnt_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      q_data.first_x  = req_data.first_x;
      q_data.first_y  = req_data.first_y;
      q_data.second_x = req_data.second_x;
      q_data.second_y = req_data.second_y;
      q_data.do_score = do_score;
      q_data.last     = req_data.last_point;
      cnt_in = cnt_ff;
      if (q_push) begin
         if (req_data.last_point) begin
            cnt_in = '0;
         end else if (do_score) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- design/hts_div.sv -----
// Restoring divider for the perspective divide, one quotient bit a cycle,
// with the quotient saturated where it clamps the error anyway. Depends on hts_pkg.
`timescale 1ns / 1ps
module hts_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [hts_pkg::DOT_W-1:0] num,
   input  logic signed [hts_pkg::DOT_W-1:0] den,
   output logic                            done,
   output logic signed [hts_pkg::Q_W-1:0]   quo
);
   import hts_pkg::*;

   logic [DOT_W-1:0]   n_mag, d_mag;
   logic               ovf;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               sat_ff, sat_in;
   logic               neg_ff, neg_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic [DOT_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [DOT_W-1:0]   den_ff, den_in;
   logic [DOT_W:0]     trial;
   logic               ge;
   logic [QUO_W-1:0]   mag;

   assign n_mag = num[DOT_W-1] ? DOT_W'(-num) : DOT_W'(num);
   assign d_mag = den[DOT_W-1] ? DOT_W'(-den) : DOT_W'(den);
   assign ovf   = {{PRE_SHIFT{1'b0}}, n_mag} >= {d_mag, {PRE_SHIFT{1'b0}}};
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         neg_in  = num[DOT_W-1] ^ den[DOT_W-1];
         den_in  = d_mag;
         step_in = '0;
         rem_in  = {{PRE_SHIFT{1'b0}}, n_mag[DOT_W-1:PRE_SHIFT]};
         quo_in  = {n_mag[PRE_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
         sat_in  = ovf;
         busy_in = !ovf;
         done_in = ovf;
      end else if (busy_ff) begin
         rem_in  = ge ? DOT_W'(trial - {1'b0, den_ff}) : trial[DOT_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == DSTEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      sat_ff  <= sat_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mag  = sat_ff ? '1 : quo_ff;
   assign done = done_ff;
   assign quo  = neg_ff ? $signed(-{1'b0, mag}) : $signed({1'b0, mag});

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("Divider started while busy.");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("Divider reports done while still busy.");

endmodule

// ----- design/hts_back.sv -----
// Back part: maps each scored point both ways, forms the score terms, keeps
// the running sum and count, and divides out the mean. Depends on hts_pkg, hts_div.
`timescale 1ns / 1ps
module hts_back (
   input  logic             clock,
   input  logic             reset,
   input  hts_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  hts_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hts_pkg::rsp_type rsp_data
);
   import hts_pkg::*;

   back_state_type          state_ff, state_in;
   job_type                 job_ff, job_in;
   logic                    dir_ff, dir_in;
   logic [1:0]              row_ff, row_in;
   logic signed [DOT_W-1:0] num_x_ff, num_x_in, num_y_ff, num_y_in, den_ff, den_in;
   logic                    inf_ff, inf_in;
   logic signed [Q_W-1:0]   ux_ff, ux_in, uy_ff, uy_in;
   logic [SQ_W-1:0]         sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [TERM_W-1:0]       pair_ff, pair_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        mrem_ff, mrem_in;
   logic [SUM_W-1:0]        mquo_ff, mquo_in;
   logic [MSTEP_W-1:0]      mstep_ff, mstep_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [2:0][ROW_W-1:0]    rows;
   logic [ROW_W-1:0]         row_sel;
   logic signed [PT_W-1:0]   px, py, qx, qy, qsel;
   logic signed [COEF_W-1:0] c0, c1, c2;
   logic signed [PROD_W-1:0] prod_a, prod_b;
   logic signed [DOT_W-1:0]  dot;
   logic signed [Q_W-1:0]    usel;
   logic [DIFF_W-1:0]        diff, diff_abs;
   logic [MAG_W-1:0]         dmag;
   logic [SQ_W-1:0]          sq;
   logic [E_W-1:0]           err;
   logic [THR_W-1:0]         term;
   logic [CNT_W:0]           mtrial;
   logic                     mge;
   logic                     div_start, div_done;
   logic signed [DOT_W-1:0]  div_num;
   logic signed [Q_W-1:0]    div_q;

   hts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   assign rows = dir_ff ? cfg.inv_rows : cfg.fwd_rows;
   assign px   = dir_ff ? job_ff.second_x : job_ff.first_x;
   assign py   = dir_ff ? job_ff.second_y : job_ff.first_y;
   assign qx   = dir_ff ? job_ff.first_x : job_ff.second_x;
   assign qy   = dir_ff ? job_ff.first_y : job_ff.second_y;

   always_comb begin
      case (row_ff)
         2'd0:    row_sel = rows[0];
         2'd1:    row_sel = rows[1];
         default: row_sel = rows[2];
      endcase
   end

   assign c0     = coef(row_sel, 0);
   assign c1     = coef(row_sel, 1);
   assign c2     = coef(row_sel, 2);
   assign prod_a = c0 * px;
   assign prod_b = c1 * py;
   assign dot    = DOT_W'(prod_a) + DOT_W'(prod_b) + DOT_W'($signed({c2, 4'b0000}));

   assign qsel     = (state_ff == ST_SQX) ? qx : qy;
   assign usel     = (state_ff == ST_SQX) ? ux_ff : uy_ff;
   assign diff     = {{(DIFF_W - PT_W){qsel[PT_W-1]}}, qsel} - {usel[Q_W-1], usel};
   assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
   assign dmag     = (diff_abs[DIFF_W-1:MAG_W] != '0) ? '1 : diff_abs[MAG_W-1:0];
   assign sq       = dmag * dmag;

   assign err  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign term = (!inf_ff && (err < E_W'(cfg.error_threshold))
                  && (E_W'(cfg.gamma_offset) > err))
                 ? THR_W'(cfg.gamma_offset - err[THR_W-1:0]) : '0;

   assign mtrial = {mrem_ff, mquo_ff[SUM_W-1]};
   assign mge    = mtrial >= {1'b0, cnt_ff};

   assign div_start = (state_ff == ST_DXS) || (state_ff == ST_DYS);
   assign div_num   = (state_ff == ST_DXS) ? num_x_ff : num_y_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      dir_in       = dir_ff;
      row_in       = row_ff;
      num_x_in     = num_x_ff;
      num_y_in     = num_y_ff;
      den_in       = den_ff;
      inf_in       = inf_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      pair_in      = pair_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      mrem_in      = mrem_ff;
      mquo_in      = mquo_ff;
      mstep_in     = mstep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_head;
               dir_in = 1'b0;
               row_in = '0;
               if (q_head.do_score) begin
                  state_in = ST_DOT;
               end else if (q_head.last) begin
                  state_in = ST_MSET;
               end
            end
         end
         ST_DOT: begin
            case (row_ff)
               2'd0:    num_x_in = dot;
               2'd1:    num_y_in = dot;
               default: den_in = dot;
            endcase
            row_in = row_ff + 1'b1;
            if (row_ff == 2'd2) begin
               row_in = '0;
               inf_in = (dot == '0);
               state_in = (dot == '0) ? ST_TERM : ST_DXS;
            end
         end
         ST_DXS: state_in = ST_DXW;
         ST_DXW: begin
            if (div_done) begin
               ux_in    = div_q;
               state_in = ST_DYS;
            end
         end
         ST_DYS: state_in = ST_DYW;
         ST_DYW: begin
            if (div_done) begin
               uy_in    = div_q;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sqx_in   = sq;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqy_in   = sq;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            if (!dir_ff) begin
               pair_in  = TERM_W'(term);
               dir_in   = 1'b1;
               row_in   = '0;
               state_in = ST_DOT;
            end else begin
               sum_in   = SUM_W'(sum_ff + SUM_W'(pair_ff) + SUM_W'(term));
               cnt_in   = cnt_ff + 1'b1;
               dir_in   = 1'b0;
               state_in = job_ff.last ? ST_MSET : ST_IDLE;
            end
         end
         ST_MSET: begin
            mrem_in  = '0;
            mstep_in = '0;
            if (cnt_ff == '0) begin
               mquo_in  = '0;
               state_in = ST_OUT;
            end else begin
               mquo_in  = sum_ff;
               state_in = ST_MITER;
            end
         end
         ST_MITER: begin
            mrem_in  = mge ? CNT_W'(mtrial - {1'b0, cnt_ff}) : mtrial[CNT_W-1:0];
            mquo_in  = {mquo_ff[SUM_W-2:0], mge};
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == MSTEP_W'(SUM_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.mean_score   = mquo_ff[MEAN_W-1:0];
               rsp_data_in.inlier_count = cnt_ff;
               rsp_data_in.no_inliers   = (cnt_ff == '0);
               sum_in   = '0;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      row_ff      <= row_in;
      num_x_ff    <= num_x_in;
      num_y_ff    <= num_y_in;
      den_ff      <= den_in;
      inf_ff      <= inf_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      pair_ff     <= pair_in;
      mrem_ff     <= mrem_in;
      mquo_ff     <= mquo_in;
      mstep_ff    <= mstep_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         dir_ff       <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("Inlier count passed its limit.");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_OUT) && !rsp_valid_ff |=> rsp_valid_ff && (cnt_ff == '0))
      else $error("Result not loaded or state not cleared.");

endmodule

// ----- design/homography_transfer_score.sv -----
// Homography transfer score, top level: configuration registers, front part,
// job queue and back part. Depends on hts_pkg, hts_front, hts_queue, hts_back.
// An unscored item only passes the back part's idle state; a scored item's time
// is set by the two-way mapping through one 18-step divider used four times.
// A last item adds the bit-serial mean division.
// Synchronous reset clears sum, count, queue and result, and sets the registers
// to their reset values; the block accepts items in the cycle after reset.
`timescale 1ns / 1ps
module homography_transfer_score (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hts_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hts_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [hts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hts_pkg::ROW_W-1:0]          csr_wdata
);
   import hts_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_empty, q_push, q_pop;
   job_type q_data, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FWD_ROW0: cfg_in.fwd_rows[0] = csr_wdata;
            CSR_FWD_ROW1: cfg_in.fwd_rows[1] = csr_wdata;
            CSR_FWD_ROW2: cfg_in.fwd_rows[2] = csr_wdata;
            CSR_INV_ROW0: cfg_in.inv_rows[0] = csr_wdata;
            CSR_INV_ROW1: cfg_in.inv_rows[1] = csr_wdata;
            CSR_INV_ROW2: cfg_in.inv_rows[2] = csr_wdata;
            CSR_ERR_THR:  cfg_in.error_threshold = csr_wdata[THR_W-1:0];
            CSR_GAMMA:    cfg_in.gamma_offset = csr_wdata[THR_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd_rows        <= '0;
         cfg_ff.inv_rows        <= '0;
         cfg_ff.error_threshold <= THR_RESET;
         cfg_ff.gamma_offset    <= GAMMA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   hts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   hts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/tb_homography_transfer_score.sv -----
// Self-checking testbench for homography_transfer_score: drives correspondence sets
// through several register settings and checks each set score against a local predictor.
// Depends on hts_pkg and the homography_transfer_score design files.
`timescale 1ns / 1ps
module tb_homography_transfer_score;
   import hts_pkg::*;

   typedef struct packed {
      req_type item;
      logic    hold;
   } feed_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ROW_W-1:0] csr_wdata = '0;

   feed_entry_type   feed_queue[$];
   rsp_type          score_queue[$];
   logic             req_taken = 1'b0;
   int               gap_left = 0;
   int               burst_left = 1;
   int               stall_mode = 0;
   int               stall_count = 0;
   int               mismatches = 0;

   logic [ROW_W-1:0] fwd_rows[3];
   logic [ROW_W-1:0] inv_rows[3];
   longint           thr_now;
   longint           gamma_now;
   longint           sum_now;
   longint           count_now;
   int               shift_x;
   int               shift_y;

   homography_transfer_score uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint coef_at(logic [ROW_W-1:0] row, int j);
      logic signed [COEF_W-1:0] c;
      c = row[j*COEF_W +: COEF_W];
      return longint'(c);
   endfunction

   function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] k;
      a = c0[COEF_W-1:0];
      b = c1[COEF_W-1:0];
      k = c2[COEF_W-1:0];
      return {k, b, a};
   endfunction

   function automatic longint clamp_diff(longint d);
      if (d > 65535) return 65535;
      if (d < -65535) return -65535;
      return d;
   endfunction

   function automatic longint transfer_gain(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                                            logic [ROW_W-1:0] r2, longint px, longint py,
                                            longint qx, longint qy);
      longint nx;
      longint ny;
      longint dn;
      longint dx;
      longint dy;
      longint err;
      nx = coef_at(r0, 0) * px + coef_at(r0, 1) * py + coef_at(r0, 2) * 16;
      ny = coef_at(r1, 0) * px + coef_at(r1, 1) * py + coef_at(r1, 2) * 16;
      dn = coef_at(r2, 0) * px + coef_at(r2, 1) * py + coef_at(r2, 2) * 16;
      if (dn == 0) return 0;
      dx = clamp_diff(qx - (nx * 8192) / dn);
      dy = clamp_diff(qy - (ny * 8192) / dn);
      err = dx * dx + dy * dy;
      if (err >= thr_now) return 0;
      if (gamma_now <= err) return 0;
      return gamma_now - err;
   endfunction

   task automatic score_item(req_type it);
      longint ax;
      longint ay;
      longint bx;
      longint by;
      rsp_type r;
      ax = longint'(it.first_x);
      ay = longint'(it.first_y);
      bx = longint'(it.second_x);
      by = longint'(it.second_y);
      if (it.inlier && count_now < MAX_POINTS) begin
         sum_now = (sum_now
                    + transfer_gain(fwd_rows[0], fwd_rows[1], fwd_rows[2], ax, ay, bx, by)
                    + transfer_gain(inv_rows[0], inv_rows[1], inv_rows[2], bx, by, ax, ay))
                   & 64'h3FFF_FFFF;
         count_now++;
      end
      if (it.last_point) begin
         r = '0;
         if (count_now == 0) begin
            r.no_inliers = 1'b1;
         end else begin
            r.mean_score = MEAN_W'(sum_now / count_now);
            r.inlier_count = CNT_W'(count_now);
         end
         score_queue.insert(score_queue.size(), r);
         sum_now = 0;
         count_now = 0;
      end
   endtask

   // Transfer bookkeeping and result checking at the rising edge.
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) score_item(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (score_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = score_queue.pop_front();
            if (want.mean_score !== rsp_data.mean_score
                || want.inlier_count !== rsp_data.inlier_count
                || want.no_inliers !== rsp_data.no_inliers) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // Sender: bursts of transfers separated by random gaps.
   always @(negedge clock) begin
      feed_entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (feed_queue.size() > 0 && (!feed_queue[0].hold || score_queue.size() == 0)) begin
         e = feed_queue.pop_front();
         req_data <= e.item;
         req_valid <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall pattern chosen at random from always ready, half ready and mostly stalled.
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_count = 50;
         stall_mode = $urandom_range(0, 2);
      end
      stall_count--;
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 99) < 15);
         end
      endcase
   end

   task automatic push_item(int fx, int fy, int sx, int sy, bit inl, bit last, bit hold);
      feed_entry_type e;
      e.item.first_x = fx[15:0];
      e.item.first_y = fy[15:0];
      e.item.second_x = sx[15:0];
      e.item.second_y = sy[15:0];
      e.item.inlier = inl;
      e.item.last_point = last;
      e.hold = hold;
      feed_queue.insert(feed_queue.size(), e);
   endtask

   // Sets of correspondences consistent with the current translation, with some
   // outliers, non-inliers and completely random items mixed in.
   task automatic add_sets(int n_items, int noise_pct);
      int done;
      int len;
      int fx;
      int fy;
      bit hold;
      done = 0;
      while (done < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         hold = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++) begin
            fx = $urandom_range(0, 8000) - 4000;
            fy = $urandom_range(0, 8000) - 4000;
            if ($urandom_range(0, 99) < noise_pct)
               push_item($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                         i == len - 1, hold && i == 0);
            else
               push_item(fx, fy, fx + 16 * shift_x + $urandom_range(0, 48) - 24,
                         fy + 16 * shift_y + $urandom_range(0, 48) - 24,
                         $urandom_range(0, 9) != 0, i == len - 1, hold && i == 0);
         end
         done += len;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FWD_ROW0, CSR_FWD_ROW1, CSR_FWD_ROW2: begin
            fwd_rows[idx - CSR_FWD_ROW0] = val;
         end
         CSR_INV_ROW0, CSR_INV_ROW1, CSR_INV_ROW2: begin
            inv_rows[idx - CSR_INV_ROW0] = val;
         end
         CSR_ERR_THR: begin
            thr_now = val[THR_W-1:0];
         end
         default: begin
            gamma_now = val[THR_W-1:0];
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_shift_model(int tx, int ty, int thr, int gam);
      shift_x = tx;
      shift_y = ty;
      write_csr(CSR_FWD_ROW0, pack_row(1024, 0, tx * 1024));
      write_csr(CSR_FWD_ROW1, pack_row(0, 1024, ty * 1024));
      write_csr(CSR_FWD_ROW2, pack_row(0, 0, 1 << 19));
      write_csr(CSR_INV_ROW0, pack_row(1024, 0, -tx * 1024));
      write_csr(CSR_INV_ROW1, pack_row(0, 1024, -ty * 1024));
      write_csr(CSR_INV_ROW2, pack_row(0, 0, 1 << 19));
      write_csr(CSR_ERR_THR, ROW_W'(thr));
      write_csr(CSR_GAMMA, ROW_W'(gam));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (feed_queue.size() != 0 || req_valid || score_queue.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         fwd_rows[i] = '0;
         inv_rows[i] = '0;
      end
      thr_now = THR_RESET;
      gamma_now = GAMMA_RESET;
      sum_now = 0;
      count_now = 0;
      shift_x = 0;
      shift_y = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: every denominator is zero, plus an empty set and field extremes.
      push_item(0, 0, 0, 0, 0, 1, 0);
      push_item(-32768, -32768, 32767, 32767, 1, 0, 0);
      push_item(32767, 32767, -32768, -32768, 1, 1, 0);
      push_item(5, 6, 7, 8, 0, 1, 0);
      drain();

      set_shift_model(0, 0, 1533, 1533);
      push_item(100, 200, 100, 200, 1, 1, 0);
      push_item(-32768, 32767, -32768, 32767, 1, 0, 0);
      push_item(32767, -32768, 32767, -32768, 1, 0, 0);
      push_item(16, 16, 40, 16, 1, 0, 0);
      push_item(0, 0, 32767, -32768, 1, 1, 1);
      push_item(0, 0, 0, 0, 0, 0, 0);
      push_item(0, 0, 0, 0, 0, 1, 0);
      add_sets(420, 10);
      drain();

      set_shift_model(37, -12, 1533, 1000);
      add_sets(250, 10);
      drain();

      set_shift_model(-400, 250, 65535, 65535);
      add_sets(250, 15);
      drain();

      set_shift_model(3, 3, 0, 0);
      add_sets(120, 20);
      drain();

      set_shift_model(0, 0, 4000, 65535);
      add_sets(250, 10);
      drain();

      // Arbitrary rows and limits, including the coefficient extremes.
      for (int p = 0; p < 3; p++) begin
         for (int r = 0; r < 6; r++) begin
            if (p == 0)
               write_csr(CSR_IDX_W'(CSR_FWD_ROW0 + r),
                         (r % 2) ? pack_row(-(1 << 20), -(1 << 20), -(1 << 20))
                                 : pack_row((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
            else
               write_csr(CSR_IDX_W'(CSR_FWD_ROW0 + r), ROW_W'({$urandom, $urandom}));
         end
         write_csr(CSR_ERR_THR, ROW_W'($urandom_range(0, 65535)));
         write_csr(CSR_GAMMA, ROW_W'($urandom_range(0, 65535)));
         @(negedge clock);
         csr_we <= 1'b0;
         add_sets(150, 60);
         drain();
      end

      if (mismatches == 0 && score_queue.size() == 0) begin
         $display("[homography_transfer_score] OK");
      end else begin
         $display("[homography_transfer_score] ERROR");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("[homography_transfer_score] ERROR");
      $finish;
   end

endmodule
